// ===== sv/newton_gain_split_search_defines.svh =====
// Assertion macros shared by the split search RTL
`ifndef NEWTON_GAIN_SPLIT_SEARCH_DEFINES_SVH
`define NEWTON_GAIN_SPLIT_SEARCH_DEFINES_SVH
`ifndef SYNTHESIS
`define NGSS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("ngss assertion failed");
`define NGSS_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("ngss forbidden condition seen");
`else
`define NGSS_ASSERT(lbl, prop)
`define NGSS_NEVER(lbl, expr)
`endif
`endif

// ===== sv/ngss_pkg.sv =====
package ngss_pkg;

	localparam int MAX_BINS     = 256;
	localparam int MAX_FEATURES = 4096;
	localparam int BIN_AW       = $clog2(MAX_BINS);
	localparam int BIN_CW       = BIN_AW + 1;
	localparam int FEAT_W       = 12;
	localparam int SUM_W        = 40;
	localparam int TERM_W       = 105;
	localparam int ACC_W        = 108;
	localparam int CFG_IW       = 4;

	localparam logic [CFG_IW-1:0] CFG_LAMBDA    = CFG_IW'(0);
	localparam logic [CFG_IW-1:0] CFG_PENALTY   = CFG_IW'(1);
	localparam logic [CFG_IW-1:0] CFG_MIN_HESS  = CFG_IW'(2);
	localparam logic [CFG_IW-1:0] CFG_MIN_COUNT = CFG_IW'(3);

	typedef struct packed {
		logic signed [31:0] bin_grad;
		logic signed [31:0] bin_hess;
		logic [31:0]        bin_count;
		logic               feature_enabled;
		logic [15:0]        feature_boost;
		logic               last_bin;
		logic               last_feature;
	} bin_item_t;

	typedef struct packed {
		logic               split_found;
		logic [11:0]        best_feature;
		logic [7:0]         best_bin;
		logic signed [63:0] best_gain;
	} split_result_t;

	typedef struct packed {
		logic signed [31:0] grad;
		logic signed [31:0] hess;
		logic [31:0]        count;
	} bin_entry_t;

	// saturate a wide signed value to 64 bits
	function automatic logic signed [63:0] sat64(input logic signed [ACC_W-1:0] a);
		logic signed [63:0] r;
		if (a[ACC_W-1:63] == '0 || a[ACC_W-1:63] == '1)
			r = a[63:0];
		else if (a[ACC_W-1])
			r = {1'b1, 63'b0};
		else
			r = {1'b0, {63{1'b1}}};
		return r;
	endfunction

endpackage

// ===== sv/newton_gain_split_search.sv =====
// Each quotient is computed in one shared unit (start, 40 multiply steps, 96
// divide steps). A closing bin of an enabled feature with two or more bins first
// needs the total quotient, and each admissible split point needs two more.
// Throughput: one bin at a time; bin_stall is high while a feature is scanned.
// Reset: arst_n clears control, totals, best split and configuration registers to defaults.
`include "newton_gain_split_search_defines.svh"
module newton_gain_split_search (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     bin_valid,
	output logic                     bin_stall,
	input  ngss_pkg::bin_item_t      bin_data,
	output logic                     res_valid,
	input  logic                     res_stall,
	output ngss_pkg::split_result_t  res_data,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [ngss_pkg::CFG_IW-1:0] cfg_index,
	input  logic [31:0]              cfg_data
);
	import ngss_pkg::*;

	typedef enum logic [12:0] {
		ST_IDLE = 13'b0000000000001,
		ST_PREP = 13'b0000000000010,
		ST_TOTW = 13'b0000000000100,
		ST_RD   = 13'b0000000001000,
		ST_ACC  = 13'b0000000010000,
		ST_CHK  = 13'b0000000100000,
		ST_T1W  = 13'b0000001000000,
		ST_T2W  = 13'b0000010000000,
		ST_GAIN = 13'b0000100000000,
		ST_MUL  = 13'b0001000000000,
		ST_SEL  = 13'b0010000000000,
		ST_FIN  = 13'b0100000000000,
		ST_EMIT = 13'b1000000000000
	} state_t;

	state_t state_q;

	logic [31:0] lambda_q, penalty_q, min_hess_q, min_count_q;

	logic [BIN_CW-1:0]       bins_q;
	logic signed [SUM_W-1:0] grad_tot_q, hess_tot_q;
	logic [SUM_W-1:0]        count_tot_q;
	logic [FEAT_W-1:0]       feature_q;
	logic                    en_q, lastf_q;
	logic [15:0]             boost_q;

	logic [BIN_AW-1:0]       b_q;
	logic signed [SUM_W-1:0] gl_q, hl_q;
	logic [SUM_W-1:0]        cl_q;
	logic [TERM_W-1:0]       t0_q, t1_q, t2_q;
	logic signed [63:0]      gain_q;
	logic [79:0]             bprod_q;

	logic signed [63:0]      best_sel_q, best_gain_q;
	logic [FEAT_W-1:0]       best_feat_q;
	logic [BIN_AW-1:0]       best_bin_q;
	logic                    best_valid_q;

	logic                    res_valid_q;
	split_result_t           res_q;

	bin_entry_t              wr_entry, rd_entry;
	logic                    bin_acc, wr_en;
	logic [BIN_AW-1:0]       last_b;

	logic                    term_start, term_busy, term_done;
	logic [TERM_W-1:0]       term;
	logic signed [SUM_W-1:0] term_g, term_h;

	logic signed [SUM_W-1:0] gr, hr;
	logic [SUM_W-1:0]        cr;
	logic                    admissible;
	logic signed [ACC_W-1:0] acc, acc_half;
	logic [63:0]             gain_mag;
	logic signed [80:0]      sel_signed;
	logic signed [ACC_W-1:0] sel_wide;
	logic signed [63:0]      sel;
	logic                    take;
	logic                    scan_end;

	assign bin_stall = (state_q != ST_IDLE);
	assign bin_acc   = bin_valid && !bin_stall;
	assign wr_en     = bin_acc && !bins_q[BIN_CW-1];
	assign cfg_ready = 1'b1;
	assign last_b    = BIN_AW'(bins_q - BIN_CW'(2));
	assign scan_end  = (b_q == last_b);

	assign wr_entry.grad  = bin_data.bin_grad;
	assign wr_entry.hess  = bin_data.bin_hess;
	assign wr_entry.count = bin_data.bin_count;

	ngss_bin_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (bins_q[BIN_AW-1:0]),
		.wr_data (wr_entry),
		.rd_addr (b_q),
		.rd_data (rd_entry)
	);

	always_comb begin
		gr = grad_tot_q - gl_q;
		hr = hess_tot_q - hl_q;
		cr = count_tot_q - cl_q;
		admissible = (cl_q >= SUM_W'(min_count_q)) && (cr >= SUM_W'(min_count_q)) &&
			(hl_q >= $signed(SUM_W'(min_hess_q))) && (hr >= $signed(SUM_W'(min_hess_q)));

		term_start = 1'b0;
		term_g     = grad_tot_q;
		term_h     = hess_tot_q;
		case (state_q)
			ST_PREP: term_start = en_q && (bins_q >= BIN_CW'(2));
			ST_CHK: begin
				term_start = admissible;
				term_g     = gl_q;
				term_h     = hl_q;
			end
			ST_T1W: begin
				term_start = term_done;
				term_g     = gr;
				term_h     = hr;
			end
			default: term_start = 1'b0;
		endcase

		acc      = $signed(ACC_W'(t1_q)) + $signed(ACC_W'(t2_q)) - $signed(ACC_W'(t0_q));
		acc_half = (acc >>> 1) - $signed(ACC_W'({penalty_q, 16'b0}));
		gain_mag = gain_q[63] ? 64'(-gain_q) : gain_q;

		sel_signed = gain_q[63] ? -$signed({1'b0, bprod_q}) : $signed({1'b0, bprod_q});
		sel_wide   = $signed({{(ACC_W-81){sel_signed[80]}}, sel_signed}) >>> 8;
		sel        = sat64(sel_wide);
		take       = !best_valid_q || (sel > best_sel_q);
	end

	ngss_term_unit u_term (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (term_start),
		.g      (term_g),
		.h      (term_h),
		.lambda (lambda_q),
		.busy   (term_busy),
		.done   (term_done),
		.term   (term)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lambda_q    <= 32'd65536;
			penalty_q   <= 32'd0;
			min_hess_q  <= 32'd65536;
			min_count_q <= 32'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LAMBDA:    lambda_q    <= cfg_data;
				CFG_PENALTY:   penalty_q   <= cfg_data;
				CFG_MIN_HESS:  min_hess_q  <= cfg_data;
				CFG_MIN_COUNT: min_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_TOTW: if (term_done) t0_q <= term;
			ST_T1W:  if (term_done) t1_q <= term;
			ST_T2W:  if (term_done) t2_q <= term;
			ST_GAIN: gain_q <= sat64(acc_half);
			ST_MUL:  bprod_q <= gain_mag * boost_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			bins_q       <= '0;
			grad_tot_q   <= '0;
			hess_tot_q   <= '0;
			count_tot_q  <= '0;
			feature_q    <= '0;
			en_q         <= 1'b0;
			lastf_q      <= 1'b0;
			boost_q      <= '0;
			b_q          <= '0;
			gl_q         <= '0;
			hl_q         <= '0;
			cl_q         <= '0;
			best_sel_q   <= {1'b1, 63'b0};
			best_gain_q  <= {1'b1, 63'b0};
			best_feat_q  <= '0;
			best_bin_q   <= '0;
			best_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
			res_q        <= '0;
		end else begin
			if (res_valid_q && !res_stall)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (bin_acc) begin
						if (!bins_q[BIN_CW-1]) begin
							grad_tot_q  <= grad_tot_q + SUM_W'(bin_data.bin_grad);
							hess_tot_q  <= hess_tot_q + SUM_W'(bin_data.bin_hess);
							count_tot_q <= count_tot_q + SUM_W'(bin_data.bin_count);
							bins_q      <= bins_q + BIN_CW'(1);
						end
						if (bin_data.last_bin) begin
							en_q    <= bin_data.feature_enabled;
							boost_q <= bin_data.feature_boost;
							lastf_q <= bin_data.last_feature;
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					b_q  <= '0;
					gl_q <= '0;
					hl_q <= '0;
					cl_q <= '0;
					state_q <= term_start ? ST_TOTW : ST_FIN;
				end
				ST_TOTW: if (term_done) state_q <= ST_RD;
				ST_RD:   state_q <= ST_ACC;
				ST_ACC: begin
					gl_q <= gl_q + SUM_W'(rd_entry.grad);
					hl_q <= hl_q + SUM_W'(rd_entry.hess);
					cl_q <= cl_q + SUM_W'(rd_entry.count);
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (admissible)
						state_q <= ST_T1W;
					else if (scan_end)
						state_q <= ST_FIN;
					else begin
						b_q     <= b_q + BIN_AW'(1);
						state_q <= ST_RD;
					end
				end
				ST_T1W:  if (term_done) state_q <= ST_T2W;
				ST_T2W:  if (term_done) state_q <= ST_GAIN;
				ST_GAIN: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_SEL;
				ST_SEL: begin
					if (take) begin
						best_valid_q <= 1'b1;
						best_sel_q   <= sel;
						best_gain_q  <= gain_q;
						best_feat_q  <= feature_q;
						best_bin_q   <= b_q;
					end
					if (scan_end)
						state_q <= ST_FIN;
					else begin
						b_q     <= b_q + BIN_AW'(1);
						state_q <= ST_RD;
					end
				end
				ST_FIN: begin
					bins_q      <= '0;
					grad_tot_q  <= '0;
					hess_tot_q  <= '0;
					count_tot_q <= '0;
					feature_q   <= (feature_q == FEAT_W'(MAX_FEATURES - 1)) ? '0 :
						feature_q + FEAT_W'(1);
					state_q     <= lastf_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					// hold until the previous result has been transferred
					if (!res_valid_q) begin
						res_valid_q       <= 1'b1;
						res_q.split_found <= best_valid_q;
						res_q.best_feature <= best_valid_q ? best_feat_q : '0;
						res_q.best_bin    <= best_valid_q ? best_bin_q : '0;
						res_q.best_gain   <= best_valid_q ? best_gain_q : {1'b1, 63'b0};
						best_sel_q        <= {1'b1, 63'b0};
						best_gain_q       <= {1'b1, 63'b0};
						best_feat_q       <= '0;
						best_bin_q        <= '0;
						best_valid_q      <= 1'b0;
						feature_q         <= '0;
						state_q           <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	`NGSS_NEVER(a_start_busy, term_start && term_busy)
	`NGSS_ASSERT(a_emit_load, (state_q == ST_EMIT && !res_valid_q) |=> (res_valid_q && !best_valid_q && state_q == ST_IDLE))
	`NGSS_ASSERT(a_scan_bound, (state_q == ST_ACC) |-> (b_q <= last_b))

endmodule

// ===== sv/ngss_bin_store.sv =====
module ngss_bin_store (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [ngss_pkg::BIN_AW-1:0] wr_addr,
	input  ngss_pkg::bin_entry_t      wr_data,
	input  logic [ngss_pkg::BIN_AW-1:0] rd_addr,
	output ngss_pkg::bin_entry_t      rd_data
);
	import ngss_pkg::*;

	bin_entry_t mem_q [MAX_BINS];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== sv/ngss_term_unit.sv =====
module ngss_term_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [ngss_pkg::SUM_W-1:0] g,
	input  logic signed [ngss_pkg::SUM_W-1:0] h,
	input  logic [31:0]                      lambda,
	output logic                             busy,
	output logic                             done,
	output logic [ngss_pkg::TERM_W-1:0]      term
);
	import ngss_pkg::*;

	localparam int PROD_W = 2 * SUM_W;
	localparam int NUM_W  = PROD_W + 16;
	localparam int DEN_W  = SUM_W + 1;
	localparam int REM_W  = DEN_W + 1;

	typedef enum logic [2:0] {
		TU_IDLE = 3'b001,
		TU_MUL  = 3'b010,
		TU_DIV  = 3'b100
	} tu_state_t;

	tu_state_t          state_q;
	logic [PROD_W-1:0]  mcand_q;
	logic [SUM_W-1:0]   mplier_q;
	logic [PROD_W-1:0]  prod_q;
	logic [DEN_W-1:0]   den_q;
	logic [REM_W-1:0]   rem_q;
	logic [NUM_W-1:0]   quo_q;
	logic [6:0]         cnt_q;
	logic               done_q;
	logic [TERM_W-1:0]  term_q;

	logic signed [DEN_W-1:0] den;
	logic [SUM_W-1:0]        mag;
	logic [PROD_W-1:0]       prod_next;
	logic [REM_W-1:0]        rem_shift;
	logic [REM_W-1:0]        rem_diff;
	logic                    q_bit;
	logic [REM_W-1:0]        rem_next;
	logic [NUM_W-1:0]        quo_next;

	always_comb begin
		den       = {h[SUM_W-1], h} + $signed({{(DEN_W-32){1'b0}}, lambda});
		mag       = g[SUM_W-1] ? SUM_W'(-g) : g;
		prod_next = prod_q + (mplier_q[0] ? mcand_q : '0);
		rem_shift = {rem_q[REM_W-2:0], quo_q[NUM_W-1]};
		rem_diff  = rem_shift - {1'b0, den_q};
		q_bit     = !rem_diff[REM_W-1];
		rem_next  = q_bit ? rem_diff : rem_shift;
		quo_next  = {quo_q[NUM_W-2:0], q_bit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TU_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				TU_IDLE: begin
					if (start) begin
						if (den[DEN_W-1] || den == '0) begin
							// non-positive denominator: zero or a huge constant
							term_q <= (g == '0) ? '0 : (TERM_W'(1) << 104);
							done_q <= 1'b1;
						end else begin
							den_q    <= den;
							mcand_q  <= PROD_W'(mag);
							mplier_q <= mag;
							prod_q   <= '0;
							cnt_q    <= 7'(SUM_W - 1);
							state_q  <= TU_MUL;
						end
					end
				end
				TU_MUL: begin
					prod_q   <= prod_next;
					mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[SUM_W-1:1]};
					cnt_q    <= cnt_q - 7'd1;
					if (cnt_q == '0) begin
						quo_q   <= {prod_next, 16'b0};
						rem_q   <= '0;
						cnt_q   <= 7'(NUM_W - 1);
						state_q <= TU_DIV;
					end
				end
				TU_DIV: begin
					rem_q <= rem_next;
					quo_q <= quo_next;
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == '0) begin
						term_q  <= TERM_W'(quo_next);
						done_q  <= 1'b1;
						state_q <= TU_IDLE;
					end
				end
				default: state_q <= TU_IDLE;
			endcase
		end
	end

	assign busy = (state_q != TU_IDLE);
	assign done = done_q;
	assign term = term_q;

endmodule

// ===== tb/newton_gain_split_search_test.sv =====
`timescale 1ns / 100ps
module newton_gain_split_search_test;
	import ngss_pkg::*;

	localparam longint CYCLE_LIMIT = 3_000_000;

	logic                clk;
	logic                arst_n;
	logic                bin_valid;
	logic                bin_stall;
	bin_item_t           bin_data;
	logic                res_valid;
	logic                res_stall;
	split_result_t       res_data;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_IW-1:0]   cfg_index;
	logic [31:0]         cfg_data;

	newton_gain_split_search dut (
		.clk(clk), .arst_n(arst_n),
		.bin_valid(bin_valid), .bin_stall(bin_stall), .bin_data(bin_data),
		.res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// split predictor state
	logic [31:0]         lambda_q, penalty_q, min_hess_q, min_count_q;
	longint              grad_mem [MAX_BINS];
	longint              hess_mem [MAX_BINS];
	longint unsigned     cnt_mem [MAX_BINS];
	int                  bins_held;
	longint              grad_sum, hess_sum;
	longint unsigned     cnt_sum;
	int                  feat_idx;
	longint              best_rank, best_gain;
	int                  best_feat, best_bin;
	bit                  best_ok;

	split_result_t       split_q [$];
	int                  errors;
	int                  bins_sent;
	int                  splits_checked;
	longint              cycles;
	bit                  idle_on;
	bit                  hold_req;
	int                  stall_left;

	function automatic logic signed [127:0] newton_quot(longint g, longint h);
		longint       d;
		logic [127:0] mag;
		logic [127:0] num;
		d = h + longint'({32'b0, lambda_q});
		if (d <= 0)
			return (g == 0) ? 128'd0 : (128'd1 << 104);
		mag = (g < 0) ? 128'(-g) : 128'(g);
		num = (mag * mag) << 16;
		return num / 128'(d);
	endfunction

	function automatic longint clamp64(logic signed [127:0] a);
		if (a[127:63] == '0 || a[127:63] == '1)
			return a[63:0];
		return a[127] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
	endfunction

	function automatic void scan_points(logic [15:0] boost);
		longint              gl, hl, gr, hr, gain, rank;
		longint unsigned     cl, cr;
		logic signed [127:0] acc, gw, bw;
		gl = 0;
		hl = 0;
		cl = 0;
		for (int b = 0; b + 1 < bins_held; b++) begin
			gl += grad_mem[b];
			hl += hess_mem[b];
			cl += cnt_mem[b];
			gr = grad_sum - gl;
			hr = hess_sum - hl;
			cr = cnt_sum - cl;
			if (cl < min_count_q || cr < min_count_q)
				continue;
			if (hl < longint'({32'b0, min_hess_q}) || hr < longint'({32'b0, min_hess_q}))
				continue;
			acc = newton_quot(gl, hl) + newton_quot(gr, hr) - newton_quot(grad_sum, hess_sum);
			acc = acc >>> 1;
			acc = acc - ({96'b0, penalty_q} << 16);
			gain = clamp64(acc);
			gw = 128'(gain);
			bw = {112'b0, boost};
			rank = clamp64((gw * bw) >>> 8);
			if (!best_ok || rank > best_rank) begin
				best_ok = 1'b1;
				best_rank = rank;
				best_gain = gain;
				best_feat = feat_idx;
				best_bin = b;
			end
		end
	endfunction

	function automatic void clear_best();
		best_rank = {1'b1, 63'b0};
		best_gain = {1'b1, 63'b0};
		best_feat = 0;
		best_bin = 0;
		best_ok = 1'b0;
	endfunction

	function automatic void predict_bin(bin_item_t it);
		split_result_t e;
		if (bins_held < MAX_BINS) begin
			grad_mem[bins_held] = longint'(it.bin_grad);
			hess_mem[bins_held] = longint'(it.bin_hess);
			cnt_mem[bins_held] = {32'b0, it.bin_count};
			grad_sum += longint'(it.bin_grad);
			hess_sum += longint'(it.bin_hess);
			cnt_sum += {32'b0, it.bin_count};
			bins_held++;
		end
		if (!it.last_bin)
			return;
		if (it.feature_enabled)
			scan_points(it.feature_boost);
		bins_held = 0;
		grad_sum = 0;
		hess_sum = 0;
		cnt_sum = 0;
		feat_idx = (feat_idx + 1 >= MAX_FEATURES) ? 0 : feat_idx + 1;
		if (!it.last_feature)
			return;
		e.split_found = best_ok;
		e.best_feature = best_ok ? best_feat[11:0] : '0;
		e.best_bin = best_ok ? best_bin[7:0] : '0;
		e.best_gain = best_gain;
		split_q.push_back(e);
		clear_best();
		feat_idx = 0;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result side: check each transfer, then draw the stall for the next one
	always @(posedge clk) begin
		split_result_t e;
		bit            take;
		if (arst_n) begin
			take = res_valid && !res_stall;
			if (take) begin
				if (split_q.size() == 0) begin
					$display("unexpected split result %h at cycle %0d", res_data, cycles);
					errors++;
				end else begin
					e = split_q.pop_front();
					splits_checked++;
					if (res_data.split_found !== e.split_found)
						report_mismatch("split_found", 64'(res_data.split_found),
							64'(e.split_found));
					if (res_data.best_feature !== e.best_feature)
						report_mismatch("best_feature", 64'(res_data.best_feature),
							64'(e.best_feature));
					if (res_data.best_bin !== e.best_bin)
						report_mismatch("best_bin", 64'(res_data.best_bin), 64'(e.best_bin));
					if (res_data.best_gain !== e.best_gain)
						report_mismatch("best_gain", res_data.best_gain, e.best_gain);
				end
				stall_left = idle_on ? $urandom_range(0, 18) : 0;
			end else if (stall_left > 0)
				stall_left--;
			if (hold_req) begin
				stall_left = 2000;
				hold_req = 1'b0;
			end
			res_stall <= (stall_left > 0);
		end
	end

	task automatic send_bin(bin_item_t it);
		int gap;
		gap = idle_on ? $urandom_range(0, 18) : 0;
		if (gap > 0) begin
			bin_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		bin_valid <= 1'b1;
		bin_data <= it;
		@(posedge clk);
		while (bin_stall)
			@(posedge clk);
		predict_bin(it);
		bins_sent++;
	endtask

	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_LAMBDA:    lambda_q = val;
			CFG_PENALTY:   penalty_q = val;
			CFG_MIN_HESS:  min_hess_q = val;
			CFG_MIN_COUNT: min_count_q = val;
			default: ;
		endcase
	endtask

	// drain all results, then let the block settle before touching registers
	task automatic drain();
		bin_valid <= 1'b0;
		@(posedge clk);
		while (split_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		while (bin_stall)
			@(posedge clk);
	endtask

	task automatic write_all(logic [31:0] lam, logic [31:0] pen, logic [31:0] mh,
		logic [31:0] mc);
		write_reg(CFG_LAMBDA, lam);
		write_reg(CFG_PENALTY, pen);
		write_reg(CFG_MIN_HESS, mh);
		write_reg(CFG_MIN_COUNT, mc);
	endtask

	function automatic bin_item_t make_bin(bit lb, bit lf);
		bin_item_t it;
		if ($urandom_range(0, 5) == 0) begin
			it.bin_grad = $urandom;
			it.bin_hess = $urandom;
			it.bin_count = $urandom;
		end else begin
			it.bin_grad = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
			it.bin_hess = $urandom_range(0, 4 << 16);
			it.bin_count = $urandom_range(0, 20);
		end
		it.feature_enabled = ($urandom_range(0, 99) < 85);
		it.feature_boost = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(128, 512));
		it.last_bin = lb;
		it.last_feature = lf;
		return it;
	endfunction

	// one node: nfeat features of 1..maxbins bins, plus stray bins with last_feature marks
	task automatic run_node(int nfeat, int maxbins, int noise_pct);
		int        nb;
		bin_item_t it;
		for (int f = 0; f < nfeat; f++) begin
			nb = $urandom_range(1, maxbins);
			for (int i = 0; i < nb; i++) begin
				if ($urandom_range(0, 99) < noise_pct)
					send_bin(make_bin(1'b0, 1'b1));
				it = make_bin(i == nb - 1, (i == nb - 1) && (f == nfeat - 1));
				send_bin(it);
			end
		end
	endtask

	function automatic bin_item_t fixed_bin(int g, int h, int c, bit en, int boost, bit lb,
		bit lf);
		bin_item_t it;
		it.bin_grad = g;
		it.bin_hess = h;
		it.bin_count = c;
		it.feature_enabled = en;
		it.feature_boost = 16'(boost);
		it.last_bin = lb;
		it.last_feature = lf;
		return it;
	endfunction

	task automatic test_directed();
		idle_on = 1'b0;
		// plain two-bin feature, then extremes of grad and count
		send_bin(fixed_bin(2 << 16, 2 << 16, 3, 1, 256, 0, 0));
		send_bin(fixed_bin(-(2 << 16), 2 << 16, 3, 1, 256, 1, 0));
		send_bin(fixed_bin(32'h7fffffff, 32'h7fffffff, -1, 1, 16'hffff, 0, 0));
		send_bin(fixed_bin(32'h80000000, 32'h7fffffff, -1, 1, 16'hffff, 1, 0));
		// short feature and a disabled one
		send_bin(fixed_bin(5 << 16, 5 << 16, 9, 1, 256, 1, 0));
		send_bin(fixed_bin(9 << 16, 3 << 16, 4, 0, 512, 0, 0));
		send_bin(fixed_bin(-(9 << 16), 3 << 16, 4, 0, 512, 1, 0));
		// zero boost, with a stray last_feature on the first bin
		send_bin(fixed_bin(1 << 16, 1 << 16, 1, 1, 0, 0, 1));
		send_bin(fixed_bin(0, 1 << 16, 1, 1, 0, 1, 1));
		// node whose only feature is disabled, so no split is found
		send_bin(fixed_bin(1 << 16, 1 << 16, 1, 0, 256, 0, 0));
		send_bin(fixed_bin(1 << 16, 1 << 16, 1, 0, 256, 1, 1));
		drain();
		// zero and negative denominators, no penalty, loose limits
		write_all(32'd0, 32'd0, 32'd0, 32'd0);
		send_bin(fixed_bin(0, 0, 0, 1, 256, 0, 0));
		send_bin(fixed_bin(3 << 16, -(1 << 16), 0, 1, 256, 0, 0));
		send_bin(fixed_bin(0, 1 << 16, 0, 1, 256, 1, 0));
		// ties: identical features, lowest wins
		send_bin(fixed_bin(1 << 16, 1 << 16, 1, 1, 256, 0, 0));
		send_bin(fixed_bin(1 << 16, 1 << 16, 1, 1, 256, 1, 0));
		send_bin(fixed_bin(1 << 16, 1 << 16, 1, 1, 256, 0, 0));
		send_bin(fixed_bin(1 << 16, 1 << 16, 1, 1, 256, 1, 1));
		drain();
	endtask

	task automatic test_config_extremes();
		logic [31:0] lam [5] = '{32'd0, 32'hffffffff, 32'd65536, 32'd1, 32'd300};
		logic [31:0] pen [5] = '{32'hffffffff, 32'd0, 32'd0, 32'h00010000, 32'd7};
		logic [31:0] mh  [5] = '{32'd0, 32'hffffffff, 32'd0, 32'd65536, 32'd100};
		logic [31:0] mc  [5] = '{32'd0, 32'd0, 32'hffffffff, 32'd1, 32'd3};
		idle_on = 1'b1;
		for (int s = 0; s < 5; s++) begin
			write_all(lam[s], pen[s], mh[s], mc[s]);
			repeat (3) run_node($urandom_range(1, 4), 6, 5);
			drain();
		end
	endtask

	task automatic test_backpressure();
		idle_on = 1'b0;
		write_all(32'd65536, 32'd0, 32'd0, 32'd1);
		hold_req = 1'b1;
		repeat (6) run_node(1, 2, 0);
		drain();
	endtask

	task automatic test_oversized_feature();
		idle_on = 1'b1;
		// bins past the store depth are dropped, flags still act
		for (int i = 0; i < MAX_BINS + 4; i++)
			send_bin(make_bin(i == MAX_BINS + 3, i == MAX_BINS + 3));
		drain();
	endtask

	task automatic test_random();
		int start;
		start = bins_sent;
		for (int p = 0; bins_sent - start < 400; p++) begin
			idle_on = (p % 3 != 2);
			write_all($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2 << 16),
				$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 14),
				$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 16),
				$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3));
			repeat (8) run_node($urandom_range(1, 5), 8, 4);
			drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		bin_valid = 1'b0;
		bin_data = '0;
		res_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		bins_sent = 0;
		splits_checked = 0;
		cycles = 0;
		idle_on = 1'b0;
		hold_req = 1'b0;
		stall_left = 0;
		lambda_q = 32'd65536;
		penalty_q = 32'd0;
		min_hess_q = 32'd65536;
		min_count_q = 32'd1;
		bins_held = 0;
		grad_sum = 0;
		hess_sum = 0;
		cnt_sum = 0;
		feat_idx = 0;
		clear_best();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_backpressure();
		test_oversized_feature();
		test_random();
		repeat (200) @(posedge clk);
		$display("covered %0d bins and %0d node splits across directed, register sweep,",
			bins_sent, splits_checked);
		$display("stall pressure, oversized feature and random phases; %0d mismatches", errors);
		if (errors == 0 && split_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
